// ===== src/sit_pkg.sv =====
`default_nettype none

package sit_pkg;

   localparam int OP_W     = 2;
   localparam int KEY_W    = 32;
   localparam int REC_W    = 31;
   localparam int STATUS_W = 2;

   localparam int DEFAULT_TABLE_DEPTH = 256;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      RSP_OK        = 2'd0,
      RSP_NOT_FOUND = 2'd1,
      RSP_FULL      = 2'd2
   } status_type;

endpackage

`default_nettype wire

// ===== src/sit_if.sv =====
`default_nettype none

interface sit_req_if;
   import sit_pkg::*;

   logic                     valid;
   logic                     ready;
   logic        [OP_W-1:0]   op;
   logic signed [KEY_W-1:0]  key_id;
   logic        [REC_W-1:0]  record_number;

   modport source (output valid, output op, output key_id, output record_number,
                   input ready);
   modport sink   (input valid, input op, input key_id, input record_number,
                   output ready);
endinterface

interface sit_rsp_if;
   import sit_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [REC_W-1:0]      found_record;

   modport source (output valid, output status, output found_record, input ready);
   modport sink   (input valid, input status, input found_record, output ready);
endinterface

`default_nettype wire

// ===== src/sorted_index_table_unit.sv =====
// clear, unused op and insert into a full table go straight to the response;
// insert shifts each larger stored entry up, one stored entry per cycle, through
// the table's one read port and one write port; lookup is a binary search
// one request in flight; the next is taken while the previous result waits
// reset clears the entry count and handshake state, table memory is not cleared
`default_nettype none

module sorted_index_table_unit #(
   parameter int TABLE_DEPTH = sit_pkg::DEFAULT_TABLE_DEPTH
) (
   input  wire      clock,
   input  wire      reset,
   sit_req_if.sink  req,
   sit_rsp_if.source rsp
);
   import sit_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = KEY_W + REC_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_CMP,
      S_INS_WRITE,
      S_LK_PROBE,
      S_LK_CMP,
      S_RESP
   } state_type;

   state_type               state_ff;
   logic [CW-1:0]           count_ff;
   logic [AW-1:0]           pos_ff;
   logic [CW-1:0]           low_ff;
   logic [CW-1:0]           hi1_ff;
   logic [AW-1:0]           mid_ff;
   logic signed [KEY_W-1:0] key_ff;
   logic [REC_W-1:0]        rec_ff;
   status_type              status_ff;
   logic [REC_W-1:0]        found_ff;
   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   logic [REC_W-1:0]        rsp_found_ff;

   logic [EW-1:0]           mem_ff [TABLE_DEPTH];
   logic [EW-1:0]           rd_data_ff;

   logic [AW-1:0]           rd_addr;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [EW-1:0]           wr_data;
   logic signed [KEY_W-1:0] rd_key;
   logic [REC_W-1:0]        rd_rec;
   logic                    shift_hit;
   logic [CW:0]             mid_sum;
   logic [AW-1:0]           mid;

   assign rd_key    = rd_data_ff[EW-1:REC_W];
   assign rd_rec    = rd_data_ff[REC_W-1:0];
   assign shift_hit = rd_key > key_ff;
   assign mid_sum   = {1'b0, low_ff} + {1'b0, hi1_ff} - {{CW{1'b0}}, 1'b1};
   assign mid       = mid_sum[AW:1];

   assign req.ready        = (state_ff == S_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.found_record = rsp_found_ff;

   // table port control
   always_comb begin
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = rd_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            rd_addr = count_ff[AW-1:0] - AW'(1);
         end
         S_INS_CMP: begin
            rd_addr = pos_ff - AW'(2);
            wr_en   = shift_hit;
         end
         S_INS_WRITE: begin
            wr_en   = 1'b1;
            wr_data = {key_ff, rec_ff};
         end
         S_LK_PROBE: begin
            rd_addr = mid;
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready && state_ff != S_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  key_ff    <= req.key_id;
                  rec_ff    <= req.record_number;
                  status_ff <= (req.op == OP_INSERT && count_ff == CW'(TABLE_DEPTH)) ?
                               RSP_FULL : RSP_OK;
                  found_ff  <= '0;
                  unique case (op_type'(req.op))
                     OP_INSERT: begin
                        pos_ff <= count_ff[AW-1:0];
                        if (count_ff == CW'(TABLE_DEPTH)) begin
                           state_ff <= S_RESP;
                        end else if (count_ff == '0) begin
                           state_ff <= S_INS_WRITE;
                        end else begin
                           state_ff <= S_INS_CMP;
                        end
                     end
                     OP_LOOKUP: begin
                        low_ff   <= '0;
                        hi1_ff   <= count_ff;
                        state_ff <= S_LK_PROBE;
                     end
                     OP_CLEAR: begin
                        count_ff <= '0;
                        state_ff <= S_RESP;
                     end
                     default: begin
                        state_ff <= S_RESP;
                     end
                  endcase
               end
            end
            S_INS_CMP: begin
               if (shift_hit) begin
                  pos_ff <= pos_ff - AW'(1);
                  if (pos_ff == AW'(1)) begin
                     state_ff <= S_INS_WRITE;
                  end
               end else begin
                  state_ff <= S_INS_WRITE;
               end
            end
            S_INS_WRITE: begin
               count_ff <= count_ff + CW'(1);
               state_ff <= S_RESP;
            end
            S_LK_PROBE: begin
               if (low_ff < hi1_ff) begin
                  mid_ff   <= mid;
                  state_ff <= S_LK_CMP;
               end else begin
                  status_ff <= RSP_NOT_FOUND;
                  state_ff  <= S_RESP;
               end
            end
            S_LK_CMP: begin
               if (rd_key == key_ff) begin
                  found_ff <= rd_rec;
                  state_ff <= S_RESP;
               end else begin
                  if (shift_hit) begin
                     hi1_ff <= CW'(mid_ff);
                  end else begin
                     low_ff <= CW'(mid_ff) + CW'(1);
                  end
                  state_ff <= S_LK_PROBE;
               end
            end
            S_RESP: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_found_ff  <= found_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_probe_in_table : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LK_CMP) |-> (CW'(mid_ff) < count_ff))
      else $error("lookup probe outside filled entries");

   a_shift_in_table : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_CMP) |-> (pos_ff != '0 && CW'(pos_ff) <= count_ff))
      else $error("insert shift position out of range");

   a_busy_after_transfer : assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("request taken while previous one still in progress");

   a_full_no_write : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_WRITE) |-> (count_ff < CW'(TABLE_DEPTH)))
      else $error("insert written into full table");
`endif

endmodule

`default_nettype wire

// ===== sim/sorted_index_table_unit_tb.sv =====
`timescale 1ns / 1ps

module sorted_index_table_unit_tb;
   import sit_pkg::*;

   localparam int DEPTH         = DEFAULT_TABLE_DEPTH;
   localparam int LIMIT         = 5_000_000;
   localparam int RANDOM_ITEMS  = 1800;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = DEPTH + 16;
   localparam int MAX_PRINTS    = 100;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      status_type        status;
      logic [REC_W-1:0]  rec;
   } table_result_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [KEY_W-1:0]  key;
      logic [REC_W-1:0]  rec;
      logic              fixed;
      status_type        exp_status;
      logic [REC_W-1:0]  exp_rec;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sit_req_if req_if ();
   sit_rsp_if rsp_if ();

   sorted_index_table_unit #(.TABLE_DEPTH(DEPTH)) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   // shadow copy of the table
   logic signed [KEY_W-1:0] shadow_key [DEPTH];
   logic        [REC_W-1:0] shadow_rec [DEPTH];
   int                      shadow_count = 0;

   table_result_type        pending_results [$];
   dir_row_type             dir_rows [$];
   logic signed [KEY_W-1:0] gen_keys [$];

   int err_count      = 0;
   int accepted_count = 0;
   int checked_count  = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   logic             hold_active = 1'b0;
   logic             drv_fixed   = 1'b0;
   status_type       drv_status  = RSP_OK;
   logic [REC_W-1:0] drv_rec     = '0;

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("sorted_index_table_unit_tb failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      if (err_count < MAX_PRINTS)
         $display("%0t ns error: %s", $realtime, msg);
      err_count++;
   endtask

   function automatic table_result_type apply_table_op(input logic [OP_W-1:0] op,
                                                       input logic signed [KEY_W-1:0] key,
                                                       input logic [REC_W-1:0] rec);
      table_result_type res;
      int pos;
      int lo;
      int hi;
      int mid;
      res.status = RSP_OK;
      res.rec    = '0;
      case (op)
         OP_INSERT: begin
            if (shadow_count >= DEPTH) begin
               res.status = RSP_FULL;
            end else begin
               pos = shadow_count;
               while (pos > 0 && shadow_key[pos-1] > key) begin
                  shadow_key[pos] = shadow_key[pos-1];
                  shadow_rec[pos] = shadow_rec[pos-1];
                  pos--;
               end
               shadow_key[pos] = key;
               shadow_rec[pos] = rec;
               shadow_count++;
            end
         end
         OP_LOOKUP: begin
            res.status = RSP_NOT_FOUND;
            lo = 0;
            hi = shadow_count - 1;
            while (lo <= hi) begin
               mid = (lo + hi) / 2;
               if (shadow_key[mid] == key) begin
                  res.status = RSP_OK;
                  res.rec    = shadow_rec[mid];
                  break;
               end else if (shadow_key[mid] > key) begin
                  hi = mid - 1;
               end else begin
                  lo = mid + 1;
               end
            end
         end
         OP_CLEAR: begin
            shadow_count = 0;
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : scoreboard
      table_result_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            checked_count++;
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("unexpected transfer, status %0d record %0h",
                                         rsp_if.status, rsp_if.found_record));
            end else begin
               want = pending_results.pop_front();
               if (rsp_if.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_if.status, want.status));
               if (rsp_if.found_record !== want.rec)
                  report_mismatch($sformatf("found_record %0h, expected %0h",
                                            rsp_if.found_record, want.rec));
            end
         end
         if (req_if.valid && req_if.ready) begin
            want = apply_table_op(req_if.op, req_if.key_id, req_if.record_number);
            if (drv_fixed) begin
               want.status = drv_status;
               want.rec    = drv_rec;
            end
            pending_results.push_back(want);
         end
      end
   end

   initial begin : receiver
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] key,
                            input logic [REC_W-1:0] rec, input logic fixed,
                            input status_type exp_status, input logic [REC_W-1:0] exp_rec);
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_if.valid         <= 1'b1;
      req_if.op            <= op;
      req_if.key_id        <= key;
      req_if.record_number <= rec;
      drv_fixed            <= fixed;
      drv_status           <= exp_status;
      drv_rec              <= exp_rec;
      do @(posedge clock); while (!req_if.ready);
      accepted_count++;
   endtask

   task automatic add_row(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                          input logic [REC_W-1:0] rec, input logic fixed,
                          input status_type exp_status, input logic [REC_W-1:0] exp_rec);
      dir_row_type row;
      row.op         = op;
      row.key        = key;
      row.rec        = rec;
      row.fixed      = fixed;
      row.exp_status = exp_status;
      row.exp_rec    = exp_rec;
      dir_rows.push_back(row);
   endtask

   function automatic logic signed [KEY_W-1:0] pick_key(input int mode);
      if ($urandom_range(15) == 0)
         return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      case (mode)
         0: return KEY_W'($urandom_range(15)) - KEY_W'(8);
         1: return KEY_W'($urandom_range(999)) - KEY_W'(500);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [REC_W-1:0] pick_rec();
      case ($urandom_range(15))
         0: return '0;
         1: return '1;
         default: return REC_W'($urandom());
      endcase
   endfunction

   task automatic send_lookup(input int mode);
      logic signed [KEY_W-1:0] key;
      if (gen_keys.size() != 0 && $urandom_range(3) != 0)
         key = gen_keys[$urandom_range(gen_keys.size() - 1)];
      else
         key = pick_key(mode);
      send_item(OP_LOOKUP, key, pick_rec(), 1'b0, RSP_OK, '0);
   endtask

   task automatic send_insert(input int mode);
      logic signed [KEY_W-1:0] key;
      key = pick_key(mode);
      send_item(OP_INSERT, key, pick_rec(), 1'b0, RSP_OK, '0);
      if (gen_keys.size() < DEPTH)
         gen_keys.push_back(key);
   endtask

   task automatic wait_drained();
      while (checked_count != accepted_count) @(posedge clock);
   endtask

   initial begin : stimulus
      int round;
      int mode;
      int target;
      int n_after;
      int pick;
      int random_sent;
      int full_rounds;
      logic full_round;

      req_if.valid         = 1'b0;
      req_if.op            = OP_INSERT;
      req_if.key_id        = '0;
      req_if.record_number = '0;
      round       = 0;
      random_sent = 0;
      full_rounds = 0;

      // empty table, unused op, extremes, duplicates, ignored fields
      add_row(OP_LOOKUP, 32'h0000_0000, 31'h7fff_ffff, 1'b1, RSP_NOT_FOUND, '0);
      add_row(OP_UNUSED, 32'h7fff_ffff, 31'h7fff_ffff, 1'b1, RSP_OK, '0);
      add_row(OP_INSERT, 32'h8000_0000, 31'h0000_0000, 1'b1, RSP_OK, '0);
      add_row(OP_INSERT, 32'h7fff_ffff, 31'h7fff_ffff, 1'b1, RSP_OK, '0);
      add_row(OP_INSERT, 32'h0000_0000, 31'h0000_0001, 1'b1, RSP_OK, '0);
      add_row(OP_INSERT, 32'hffff_ffff, 31'h0000_0002, 1'b1, RSP_OK, '0);
      add_row(OP_INSERT, 32'h0000_0005, 31'h0000_000a, 1'b1, RSP_OK, '0);
      add_row(OP_INSERT, 32'h0000_0005, 31'h0000_000b, 1'b1, RSP_OK, '0);
      add_row(OP_INSERT, 32'h0000_0005, 31'h0000_000c, 1'b1, RSP_OK, '0);
      add_row(OP_LOOKUP, 32'h8000_0000, 31'h1234_5678, 1'b0, RSP_OK, '0);
      add_row(OP_LOOKUP, 32'h7fff_ffff, 31'h0000_0000, 1'b0, RSP_OK, '0);
      add_row(OP_LOOKUP, 32'h0000_0005, 31'h0000_0000, 1'b0, RSP_OK, '0);
      add_row(OP_LOOKUP, 32'h0000_0004, 31'h0000_0000, 1'b0, RSP_OK, '0);
      add_row(OP_LOOKUP, 32'h0000_0000, 31'h0000_0000, 1'b0, RSP_OK, '0);
      add_row(OP_LOOKUP, 32'hffff_ffff, 31'h0000_0000, 1'b0, RSP_OK, '0);
      add_row(OP_LOOKUP, 32'h8000_0001, 31'h0000_0000, 1'b0, RSP_OK, '0);
      add_row(OP_UNUSED, 32'h0000_0005, 31'h0000_0000, 1'b1, RSP_OK, '0);
      add_row(OP_LOOKUP, 32'h0000_0005, 31'h7fff_ffff, 1'b0, RSP_OK, '0);
      add_row(OP_CLEAR,  32'h5555_aaaa, 31'h2aaa_5555, 1'b1, RSP_OK, '0);
      add_row(OP_LOOKUP, 32'h0000_0005, 31'h0000_0000, 1'b1, RSP_NOT_FOUND, '0);
      add_row(OP_CLEAR,  32'h0000_0000, 31'h0000_0000, 1'b1, RSP_OK, '0);
      add_row(OP_INSERT, 32'h1234_5678, 31'h2aaa_aaaa, 1'b1, RSP_OK, '0);
      add_row(OP_LOOKUP, 32'h1234_5678, 31'h5555_5555, 1'b1, RSP_OK, 31'h2aaa_aaaa);
      add_row(OP_LOOKUP, 32'h1234_5679, 31'h0000_0000, 1'b1, RSP_NOT_FOUND, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].rec, dir_rows[i].fixed,
                   dir_rows[i].exp_status, dir_rows[i].exp_rec);
      wait_drained();

      while (random_sent < RANDOM_ITEMS) begin
         case (round % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         full_round = (round == 1) || (full_rounds < 3 && $urandom_range(9) == 0);
         if (full_round)
            full_rounds++;
         mode   = $urandom_range(2);
         target = full_round ? DEPTH : $urandom_range(40);

         if (round == 0 || full_round || $urandom_range(5) != 0) begin
            send_item(OP_CLEAR, $urandom(), pick_rec(), 1'b0, RSP_OK, '0);
            gen_keys.delete();
            random_sent++;
         end

         // receiver held off while the sender keeps offering
         if (round == 2)
            fork
               begin
                  hold_active <= 1'b1;
                  repeat (HOLD_CYCLES) @(posedge clock);
                  hold_active <= 1'b0;
               end
            join_none

         while (gen_keys.size() < target) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               send_insert(mode);
               random_sent++;
            end else if (pick < 95) begin
               send_lookup(mode);
               random_sent++;
            end else if (pick < 98 || full_round) begin
               send_item(OP_UNUSED, $urandom(), pick_rec(), 1'b0, RSP_OK, '0);
            end else begin
               // sequence broken by a clear part way through
               send_item(OP_CLEAR, $urandom(), pick_rec(), 1'b0, RSP_OK, '0);
               gen_keys.delete();
               random_sent++;
            end
         end

         n_after = full_round ? 30 : $urandom_range(2, 15);
         for (int i = 0; i < n_after; i++) begin
            if (full_round && i < 3)
               send_insert(mode);
            else
               send_lookup(mode);
            random_sent++;
         end

         if (round == 1 || round % 4 == 3)
            wait_drained();
         round++;
      end

      req_if.valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("sorted_index_table_unit_tb passed");
      else
         $display("sorted_index_table_unit_tb failed");
      $finish;
   end

endmodule
